/* hdl/apdu_seq_pkg.sv */
// Shared types and constants for the smartcard APDU sequencer.
`timescale 1ns / 1ps
package apdu_seq_pkg;

   localparam int LEN_W = 5;
   localparam int HDR_IDX_W = 3;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST = 3'd4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_RX = 1'b1;

   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR,
      ST_WAIT_PROC,
      ST_CMD,
      ST_LEN,
      ST_WAIT_RESP,
      ST_WAIT_SW1,
      ST_WAIT_SW2,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_HDR,
      SEL_CMD,
      SEL_LEN,
      SEL_DONE
   } out_sel_type;

   typedef struct packed {
      logic        latch_start;
      logic        hdr_step;
      logic        latch_proc;
      logic        cmd_step;
      logic        shift_resp;
      logic        latch_sw1;
      logic        latch_sw2;
      logic        load_out;
      out_sel_type out_sel;
      logic        out_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hdr_last;
      logic cmd_empty;
      logic cmd_last;
      logic resp_empty;
      logic resp_last;
   } dp_status_type;

endpackage

/* hdl/apdu_seq_ctrl.sv */
// Controller state machine for the APDU exchange and result valid flag.
`timescale 1ns / 1ps
module apdu_seq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_opcode,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  apdu_seq_pkg::dp_status_type status,
   output apdu_seq_pkg::ctrl_cmd_type  cmd
);
   import apdu_seq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      emit_ok;

   assign emit_ok = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_START) state_in = ST_HDR;
         end
         ST_HDR: begin
            if (emit_ok && status.hdr_last) state_in = ST_WAIT_PROC;
         end
         ST_WAIT_PROC: begin
            if (accept && req_opcode == OP_RX) begin
               if (!status.cmd_empty) state_in = ST_CMD;
               else if (!status.resp_empty) state_in = ST_WAIT_RESP;
               else state_in = ST_WAIT_SW1;
            end
         end
         ST_CMD: begin
            if (emit_ok && status.cmd_last) begin
               state_in = status.resp_empty ? ST_WAIT_SW1 : ST_LEN;
            end
         end
         ST_LEN: begin
            if (emit_ok) state_in = ST_WAIT_RESP;
         end
         ST_WAIT_RESP: begin
            if (accept && req_opcode == OP_RX && status.resp_last) state_in = ST_WAIT_SW1;
         end
         ST_WAIT_SW1: begin
            if (accept && req_opcode == OP_RX) state_in = ST_WAIT_SW2;
         end
         ST_WAIT_SW2: begin
            if (accept && req_opcode == OP_RX) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (emit_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.out_sel = SEL_HDR;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch_start = req_valid && req_opcode == OP_START;
         end
         ST_HDR: begin
            cmd.load_out = emit_ok;
            cmd.hdr_step = emit_ok;
            cmd.out_sel = SEL_HDR;
            cmd.out_last = status.hdr_last;
         end
         ST_WAIT_PROC: begin
            req_ready = 1'b1;
            cmd.latch_proc = req_valid && req_opcode == OP_RX;
         end
         ST_CMD: begin
            cmd.load_out = emit_ok;
            cmd.cmd_step = emit_ok;
            cmd.out_sel = SEL_CMD;
            cmd.out_last = status.cmd_last && status.resp_empty;
         end
         ST_LEN: begin
            cmd.load_out = emit_ok;
            cmd.out_sel = SEL_LEN;
            cmd.out_last = 1'b1;
         end
         ST_WAIT_RESP: begin
            req_ready = 1'b1;
            cmd.shift_resp = req_valid && req_opcode == OP_RX;
         end
         ST_WAIT_SW1: begin
            req_ready = 1'b1;
            cmd.latch_sw1 = req_valid && req_opcode == OP_RX;
         end
         ST_WAIT_SW2: begin
            req_ready = 1'b1;
            cmd.latch_sw2 = req_valid && req_opcode == OP_RX;
         end
         ST_DONE: begin
            cmd.load_out = emit_ok;
            cmd.out_sel = SEL_DONE;
            cmd.out_last = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/apdu_seq_dp.sv */
// Datapath: header registers, command shift register, response collection, result register.
`timescale 1ns / 1ps
module apdu_seq_dp #(
   parameter int MAX_BYTES = 16
) (
   input  logic                        clock,
   input  logic [7:0]                  req_cla,
   input  logic [7:0]                  req_ins,
   input  logic [7:0]                  req_p1,
   input  logic [7:0]                  req_p2,
   input  logic [4:0]                  req_cmd_length,
   input  logic [4:0]                  req_resp_length,
   input  logic [63:0]                 req_command_hi,
   input  logic [63:0]                 req_command_lo,
   input  logic [7:0]                  req_rx_byte,
   input  apdu_seq_pkg::ctrl_cmd_type  cmd,
   output apdu_seq_pkg::dp_status_type status,
   output logic                        rsp_kind,
   output logic [7:0]                  rsp_tx_byte,
   output logic                        rsp_last,
   output logic                        rsp_procedure_ok,
   output logic [63:0]                 rsp_response_hi,
   output logic [63:0]                 rsp_response_lo,
   output logic [15:0]                 rsp_status_word
);
   import apdu_seq_pkg::*;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BYTES);

   logic [7:0]           cla_ff, cla_in, ins_ff, ins_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [7:0]           p3_ff, p3_in;
   logic [HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic [127:0]         cmd_sr_ff, cmd_sr_in;
   logic [LEN_W-1:0]     cmd_left_ff, cmd_left_in;
   logic [LEN_W-1:0]     resp_count_ff, resp_count_in;
   logic [LEN_W-1:0]     resp_left_ff, resp_left_in;
   logic [127:0]         resp_sr_ff, resp_sr_in;
   logic                 proc_ff, proc_in;
   logic [7:0]           sw1_ff, sw1_in, sw2_ff, sw2_in;
   logic                 kind_ff, kind_in, last_ff, last_in, pok_ff, pok_in;
   logic [7:0]           tx_ff, tx_in;
   logic [127:0]         resp_out_ff, resp_out_in;
   logic [15:0]          sw_out_ff, sw_out_in;
   logic [LEN_W-1:0]     lc, lr;
   logic [7:0]           hdr_byte;

   assign lc = (req_cmd_length > LEN_MAX) ? LEN_MAX : req_cmd_length;
   assign lr = (req_resp_length > LEN_MAX) ? LEN_MAX : req_resp_length;

   always_comb begin
      case (hdr_idx_ff)
         3'd0: hdr_byte = cla_ff;
         3'd1: hdr_byte = ins_ff;
         3'd2: hdr_byte = p1_ff;
         3'd3: hdr_byte = p2_ff;
         default: hdr_byte = p3_ff;
      endcase
   end

   always_comb begin
      cla_in = cla_ff;
      ins_in = ins_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      p3_in = p3_ff;
      hdr_idx_in = hdr_idx_ff;
      cmd_sr_in = cmd_sr_ff;
      cmd_left_in = cmd_left_ff;
      resp_count_in = resp_count_ff;
      resp_left_in = resp_left_ff;
      resp_sr_in = resp_sr_ff;
      proc_in = proc_ff;
      sw1_in = sw1_ff;
      sw2_in = sw2_ff;
      if (cmd.latch_start) begin
         cla_in = req_cla;
         ins_in = req_ins;
         p1_in = req_p1;
         p2_in = req_p2;
         p3_in = {3'b000, (lc == '0 && lr != '0) ? lr : lc};
         hdr_idx_in = '0;
         cmd_sr_in = {req_command_hi, req_command_lo};
         cmd_left_in = lc;
         resp_count_in = lr;
         resp_left_in = lr;
         resp_sr_in = '0;
         proc_in = 1'b0;
      end
      if (cmd.hdr_step) hdr_idx_in = hdr_idx_ff + 1'b1;
      if (cmd.latch_proc) proc_in = (req_rx_byte == ins_ff);
      if (cmd.cmd_step) begin
         cmd_sr_in = {cmd_sr_ff[119:0], 8'h00};
         cmd_left_in = cmd_left_ff - 1'b1;
      end
      if (cmd.shift_resp) begin
         resp_sr_in = {resp_sr_ff[119:0], req_rx_byte};
         resp_left_in = resp_left_ff - 1'b1;
      end
      if (cmd.latch_sw1) sw1_in = req_rx_byte;
      if (cmd.latch_sw2) sw2_in = req_rx_byte;
   end

   always_comb begin
      kind_in = kind_ff;
      tx_in = tx_ff;
      last_in = last_ff;
      pok_in = pok_ff;
      resp_out_in = resp_out_ff;
      sw_out_in = sw_out_ff;
      if (cmd.load_out) begin
         kind_in = KIND_TX;
         last_in = cmd.out_last;
         pok_in = 1'b0;
         resp_out_in = '0;
         sw_out_in = '0;
         case (cmd.out_sel)
            SEL_HDR: tx_in = hdr_byte;
            SEL_CMD: tx_in = cmd_sr_ff[127:120];
            SEL_LEN: tx_in = {3'b000, resp_count_ff};
            SEL_DONE: begin
               kind_in = KIND_DONE;
               tx_in = '0;
               pok_in = proc_ff;
               resp_out_in = resp_sr_ff;
               sw_out_in = {sw1_ff, sw2_ff};
            end
            default: tx_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cla_ff <= cla_in;
      ins_ff <= ins_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      p3_ff <= p3_in;
      hdr_idx_ff <= hdr_idx_in;
      cmd_sr_ff <= cmd_sr_in;
      cmd_left_ff <= cmd_left_in;
      resp_count_ff <= resp_count_in;
      resp_left_ff <= resp_left_in;
      resp_sr_ff <= resp_sr_in;
      proc_ff <= proc_in;
      sw1_ff <= sw1_in;
      sw2_ff <= sw2_in;
      kind_ff <= kind_in;
      tx_ff <= tx_in;
      last_ff <= last_in;
      pok_ff <= pok_in;
      resp_out_ff <= resp_out_in;
      sw_out_ff <= sw_out_in;
   end

   assign status.hdr_last = (hdr_idx_ff == HDR_LAST);
   assign status.cmd_empty = (cmd_left_ff == '0);
   assign status.cmd_last = (cmd_left_ff == LEN_W'(1));
   assign status.resp_empty = (resp_count_ff == '0);
   assign status.resp_last = (resp_left_ff == LEN_W'(1));

   assign rsp_kind = kind_ff;
   assign rsp_tx_byte = tx_ff;
   assign rsp_last = last_ff;
   assign rsp_procedure_ok = pok_ff;
   assign rsp_response_hi = resp_out_ff[127:64];
   assign rsp_response_lo = resp_out_ff[63:0];
   assign rsp_status_word = sw_out_ff;

endmodule

/* hdl/smartcard_apdu_sequencer_top.sv */
// Top level of the smartcard APDU sequencer.
`timescale 1ns / 1ps
// The block runs one T=0 style APDU exchange. Every transmitted byte passes through a single
// result register, one per cycle while the result receiver does not stall. A start request emits
// the five header bytes before the next request can be accepted. The procedure byte emits up to
// MAX_BYTES (16) command bytes and, when command bytes were sent and a response is expected, the
// response length byte. The second status byte leads to the done report, which also passes
// through the result register. A stall by the result receiver holds the emitting states. Requests
// that arrive while results are being emitted wait until the controller returns to a waiting state.
// Received bytes while idle and starts while a transaction is open are taken and dropped.
module smartcard_apdu_sequencer_top #(
   parameter int MAX_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_cla,
   input  logic [7:0]  req_ins,
   input  logic [7:0]  req_p1,
   input  logic [7:0]  req_p2,
   input  logic [4:0]  req_cmd_length,
   input  logic [4:0]  req_resp_length,
   input  logic [63:0] req_command_hi,
   input  logic [63:0] req_command_lo,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_procedure_ok,
   output logic [63:0] rsp_response_hi,
   output logic [63:0] rsp_response_lo,
   output logic [15:0] rsp_status_word
);
   import apdu_seq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   apdu_seq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   apdu_seq_dp #(
      .MAX_BYTES (MAX_BYTES)
   ) u_dp (
      .clock            (clock),
      .req_cla          (req_cla),
      .req_ins          (req_ins),
      .req_p1           (req_p1),
      .req_p2           (req_p2),
      .req_cmd_length   (req_cmd_length),
      .req_resp_length  (req_resp_length),
      .req_command_hi   (req_command_hi),
      .req_command_lo   (req_command_lo),
      .req_rx_byte      (req_rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_kind         (rsp_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last         (rsp_last),
      .rsp_procedure_ok (rsp_procedure_ok),
      .rsp_response_hi  (rsp_response_hi),
      .rsp_response_lo  (rsp_response_lo),
      .rsp_status_word  (rsp_status_word)
   );

endmodule

/* hdl/apdu_seq_chk.sv */
// Port-level checker for the APDU sequencer and its bind to the top level.
`timescale 1ns / 1ps
module apdu_seq_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_last,
   input logic        rsp_procedure_ok,
   input logic [63:0] rsp_response_hi,
   input logic [63:0] rsp_response_lo,
   input logic [15:0] rsp_status_word
);
   import apdu_seq_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_kind)
         && $stable(rsp_last))
      else $error("stalled result changed");

   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_TX |-> rsp_response_hi == '0 && rsp_response_lo == '0
         && rsp_status_word == '0 && !rsp_procedure_ok)
      else $error("transmit result carries report fields");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_last && rsp_tx_byte == '0)
      else $error("done report malformed");

endmodule

bind smartcard_apdu_sequencer_top apdu_seq_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_tx_byte      (rsp_tx_byte),
   .rsp_last         (rsp_last),
   .rsp_procedure_ok (rsp_procedure_ok),
   .rsp_response_hi  (rsp_response_hi),
   .rsp_response_lo  (rsp_response_lo),
   .rsp_status_word  (rsp_status_word)
);
